/* rtl/core/ers_pkg.sv */
// ----------------------------------------------------------------------------
// ers_pkg
// shared constants and types of the elevator request scheduler
// ----------------------------------------------------------------------------
package ers_pkg;

  // default building height
  localparam int ERS_FLOORS = 16;

  // input item kinds, carried on in_tuser
  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  // heading codes
  typedef logic [1:0] dir_t;
  localparam dir_t DIR_UP   = 2'd0;
  localparam dir_t DIR_DOWN = 2'd1;
  localparam dir_t DIR_IDLE = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic req_load;
    logic tick_load;
  } ers_cmd_t;

endpackage

/* rtl/core/ers_ctrl.sv */
// ----------------------------------------------------------------------------
// ers_ctrl
// handshake controller: holds the result beat and issues update commands
// ----------------------------------------------------------------------------
module ers_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  output ers_pkg::ers_cmd_t cmd
);
  import ers_pkg::*;

  localparam logic ST_EMPTY = 1'b0;
  localparam logic ST_FULL  = 1'b1;

  logic state_r;
  logic state_nxt;
  logic accept;

  // a new beat is taken when no result is held or while the held result leaves
  assign in_tready  = (state_r == ST_EMPTY) || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = (state_r == ST_FULL);

  // decode the item kind into a datapath command
  always_comb begin
    cmd.req_load  = accept && (in_tuser == OP_REQUEST);
    cmd.tick_load = accept && (in_tuser == OP_TICK);
  end

  // result holding state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_EMPTY: begin
        if (accept) state_nxt = ST_FULL;
      end
      ST_FULL: begin
        if (accept) state_nxt = ST_FULL;
        else if (out_tready) state_nxt = ST_EMPTY;
      end
      default: state_nxt = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_tvalid)
    else $error("accepted beat did not produce a result");
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("pending result dropped");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.req_load && cmd.tick_load))
    else $error("request and tick issued together");
`endif

endmodule

/* rtl/core/ers_datapath.sv */
// ----------------------------------------------------------------------------
// ers_datapath
// car state, pending floor sets and next-goal priority encoders
// ----------------------------------------------------------------------------
module ers_datapath #(
  parameter int FLOORS = ers_pkg::ERS_FLOORS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ers_pkg::ers_cmd_t cmd,
  input  logic [3:0]        req_floor,
  output logic [3:0]        current_floor,
  output ers_pkg::dir_t     direction,
  output logic              door_open,
  output logic              moving,
  output logic [3:0]        target_floor,
  output logic              down_phase
);
  import ers_pkg::*;

  localparam int FW = $clog2(FLOORS);
  localparam int W  = (FW > 4) ? FW : 4;

  logic [FW-1:0]     car_r, car_nxt;
  logic [FW-1:0]     goal_r, goal_nxt;
  logic [FLOORS-1:0] up_r, up_nxt;
  logic [FLOORS-1:0] down_r, down_nxt;
  logic              travel_r, travel_nxt;
  logic              phase_r, phase_nxt;
  dir_t              head_r, head_nxt;
  logic              door_r, door_nxt;

  logic [W-1:0]      fl_ext;
  logic [W-1:0]      car_ext;
  logic [W-1:0]      goal_ext;
  logic              fl_in_range;
  logic [FW-1:0]     lo_idx;
  logic [FW-1:0]     hi_idx;
  logic [FW-1:0]     pick;
  logic              have_pick;
  logic              phase_sel;
  logic [FW-1:0]     step_floor;

  assign fl_ext      = W'(req_floor);
  assign car_ext     = W'(car_r);
  assign goal_ext    = W'(goal_r);
  assign fl_in_range = ({1'b0, fl_ext} < (W+1)'(FLOORS));

  // lowest marked up floor
  always_comb begin
    lo_idx = '0;
    for (int i = FLOORS - 1; i >= 0; i--) begin
      if (up_r[i]) lo_idx = FW'(i);
    end
  end

  // highest marked down floor
  always_comb begin
    hi_idx = '0;
    for (int i = 0; i < FLOORS; i++) begin
      if (down_r[i]) hi_idx = FW'(i);
    end
  end

  // phase flip when the current set is empty and the other is not
  always_comb begin
    phase_sel = phase_r;
    if (!phase_r && (up_r == '0) && (down_r != '0)) phase_sel = 1'b1;
    if (phase_r && (down_r == '0) && (up_r != '0)) phase_sel = 1'b0;
    have_pick = phase_sel ? (down_r != '0) : (up_r != '0);
    pick      = phase_sel ? hi_idx : lo_idx;
  end

  // one floor toward the goal
  always_comb begin
    step_floor = car_r;
    if (goal_r > car_r) step_floor = FW'(car_r + 1'b1);
    else if (goal_r < car_r) step_floor = FW'(car_r - 1'b1);
  end

  // state update for requests and ticks
  always_comb begin
    car_nxt    = car_r;
    goal_nxt   = goal_r;
    up_nxt     = up_r;
    down_nxt   = down_r;
    travel_nxt = travel_r;
    phase_nxt  = phase_r;
    head_nxt   = head_r;
    door_nxt   = door_r;
    if (cmd.req_load && fl_in_range) begin
      if (fl_ext >= car_ext) up_nxt[fl_ext[FW-1:0]] = 1'b1;
      else down_nxt[fl_ext[FW-1:0]] = 1'b1;
    end
    if (cmd.tick_load) begin
      if (travel_r) begin
        car_nxt = step_floor;
        if (step_floor == goal_r) begin
          travel_nxt = 1'b0;
          door_nxt   = 1'b1;
        end
      end else begin
        phase_nxt = phase_sel;
        if (have_pick) begin
          if (phase_sel) down_nxt[pick] = 1'b0;
          else up_nxt[pick] = 1'b0;
          goal_nxt = pick;
          if (pick == car_r) begin
            door_nxt   = 1'b1;
            travel_nxt = 1'b0;
          end else begin
            door_nxt   = 1'b0;
            travel_nxt = 1'b1;
            head_nxt   = (pick > car_r) ? DIR_UP : DIR_DOWN;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      car_r    <= '0;
      goal_r   <= '0;
      up_r     <= '0;
      down_r   <= '0;
      travel_r <= 1'b0;
      phase_r  <= 1'b0;
      head_r   <= DIR_IDLE;
      door_r   <= 1'b0;
    end else begin
      car_r    <= car_nxt;
      goal_r   <= goal_nxt;
      up_r     <= up_nxt;
      down_r   <= down_nxt;
      travel_r <= travel_nxt;
      phase_r  <= phase_nxt;
      head_r   <= head_nxt;
      door_r   <= door_nxt;
    end
  end

  // result fields, floors cut to four bits
  assign current_floor = car_ext[3:0];
  assign target_floor  = goal_ext[3:0];
  assign direction     = head_r;
  assign door_open     = door_r;
  assign moving        = travel_r;
  assign down_phase    = phase_r;

`ifndef NO_ASSERTIONS
  a_travel_goal: assert property (@(posedge clk) disable iff (!rst_n)
    travel_r |-> (car_r != goal_r))
    else $error("travelling while already at goal");
  a_door_travel: assert property (@(posedge clk) disable iff (!rst_n)
    !(door_r && travel_r))
    else $error("door open while travelling");
  a_idle_head: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == DIR_IDLE) |-> (!travel_r && (car_r == '0)))
    else $error("car moved with idle heading");
`endif

endmodule

/* rtl/core/elevator_request_scheduler_core.sv */
// ----------------------------------------------------------------------------
// elevator_request_scheduler_core
// single-car look scheduler with alternating up and down service phases
// ----------------------------------------------------------------------------
// timing: a result beat is valid in the cycle after its item is accepted
// throughput: one item per cycle while out_tready stays high; the single
//   result register sets the rate, so a stalled result holds the input side
// reset: synchronous active-low rst_n clears both floor sets, puts the car
//   at floor zero with door closed, heading idle and the up phase first
module elevator_request_scheduler_core #(
  parameter int FLOORS = ers_pkg::ERS_FLOORS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [3:0] floor, [7:4] zero
  input  logic        in_tuser,   // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [3:0] current_floor, [5:4] direction,
                                  // [6] door_open, [7] moving,
                                  // [11:8] target_floor, [12] down_phase,
                                  // [15:13] zero
);
  import ers_pkg::*;

  ers_cmd_t   cmd;
  logic [3:0] current_floor;
  dir_t       direction;
  logic       door_open;
  logic       moving;
  logic [3:0] target_floor;
  logic       down_phase;

  // handshake controller
  ers_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // scheduler state and encoders
  ers_datapath #(
    .FLOORS (FLOORS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .req_floor     (in_tdata[3:0]),
    .current_floor (current_floor),
    .direction     (direction),
    .door_open     (door_open),
    .moving        (moving),
    .target_floor  (target_floor),
    .down_phase    (down_phase)
  );

  // pack the result beat
  assign out_tdata = {3'b000, down_phase, target_floor, moving, door_open,
                      direction, current_floor};

endmodule
